>>> hdl/assert_macros.svh
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSPS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("assertion failed");
`define CSPS_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error("forbidden state");
`else
`define CSPS_ASSERT(lbl, ck, rs, prop)
`define CSPS_NEVER(lbl, ck, rs, expr)
`endif
`endif

>>> hdl/csps_pkg.sv
// types and constants of the cpu scheduler core
package csps_pkg;

  localparam int PID_W   = 6;
  localparam int BURST_W = 10;
  localparam int TIME_W  = 16;
  localparam int RANK_W  = 8;
  localparam int POL_W   = 3;
  localparam int SLICE_W = 8;
  localparam int CFG_W   = 8;
  localparam int PROD_W  = TIME_W + 1 + BURST_W;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_NEW   = 2'd0;
  localparam phase_t PH_READY = 2'd1;
  localparam phase_t PH_RUN   = 2'd2;
  localparam phase_t PH_DONE  = 2'd3;

  localparam logic [POL_W-1:0] POL_FCFS = 3'd0;
  localparam logic [POL_W-1:0] POL_RR   = 3'd1;
  localparam logic [POL_W-1:0] POL_SJF  = 3'd2;
  localparam logic [POL_W-1:0] POL_SRTF = 3'd3;
  localparam logic [POL_W-1:0] POL_HRRN = 3'd4;
  localparam logic [POL_W-1:0] POL_PPRR = 3'd5;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SLICE  = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               op;
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic [RANK_W-1:0]  process_priority;
  } cmd_t;

  typedef struct packed {
    logic [PID_W-1:0]  slot_pid;
    logic              slot_idle;
    logic              finished;
    logic [PID_W-1:0]  finished_pid;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              all_done;
  } result_t;

  typedef struct packed {
    phase_t             phase;
    logic [TIME_W-1:0]  arrival;
    logic [RANK_W-1:0]  rank;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  waiting;
  } entry_t;

  typedef struct packed {
    logic             capture;
    logic [POL_W-1:0] policy;
  } cmp_ctl_t;

endpackage

>>> hdl/csps_ram.sv
// generic single write port ram with registered read
module csps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/csps_rank.sv
// shared compare unit that decides whether a candidate beats the current best
module csps_rank #(
  parameter int PW = 6
) (
  input  logic                clk,
  input  csps_pkg::cmp_ctl_t  ctl,
  input  csps_pkg::entry_t    best,
  input  csps_pkg::entry_t    cand,
  input  logic [PW-1:0]       best_pid,
  input  logic [PW-1:0]       cand_pid,
  output logic                better
);

  logic [csps_pkg::TIME_W:0]         op_a;
  logic [csps_pkg::BURST_W-1:0]      op_b;
  logic [csps_pkg::PROD_W-1:0]       prod;
  logic [csps_pkg::PROD_W-1:0]       lhs;

  // with capture high the best side product is formed and registered in lhs, otherwise the candidate side
  always_comb begin
    if (ctl.capture) begin
      op_a = {1'b0, best.waiting} + (csps_pkg::TIME_W+1)'(best.burst);
      op_b = cand.burst;
    end else begin
      op_a = {1'b0, cand.waiting} + (csps_pkg::TIME_W+1)'(cand.burst);
      op_b = best.burst;
    end
    prod = csps_pkg::PROD_W'(op_a) * csps_pkg::PROD_W'(op_b);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lhs <= prod;
    end
  end

  always_comb begin
    unique case (ctl.policy)
      csps_pkg::POL_SJF: begin
        if (cand.burst != best.burst) better = cand.burst < best.burst;
        else better = cand.arrival < best.arrival;
      end
      csps_pkg::POL_SRTF: begin
        if (cand.remaining != best.remaining) better = cand.remaining < best.remaining;
        else if (cand.arrival != best.arrival) better = cand.arrival < best.arrival;
        else better = cand_pid < best_pid;
      end
      csps_pkg::POL_HRRN: begin
        if (prod != lhs) better = prod > lhs;
        else if (cand.arrival != best.arrival) better = cand.arrival < best.arrival;
        else better = cand_pid < best_pid;
      end
      csps_pkg::POL_PPRR: better = cand.rank < best.rank;
      default:            better = 1'b0;
    endcase
  end

endmodule

>>> hdl/cpu_scheduling_policy_simulator_core.sv
// top level of the tick driven cpu scheduler core
//
// a command beat is taken when start is high and busy is low. a load beat
// writes one process entry and gives no result; when it restarts a queued
// pid it first searches the ready queue for that pid and closes the gap.
// a tick beat gives exactly one result, shown on result for one cycle with
// result_valid high; the receiver cannot hold it off.
// a tick walks the process table through the entry memory's single read port
// for admission, then for the waiting update when a process runs, then for
// admission at the new time; on dispatch it compares each queued process for
// the selection and closes the queue gap, and it stays busy all the while.
// policy and time_slice are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the core is idle, which the core itself
// does not enforce. reset clears the valid bits, the queue, the clock and the
// running process at once; no clearing pass is needed.
module cpu_scheduling_policy_simulator_core #(
  parameter int MAX_PROCS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  csps_pkg::cmd_t                cmd,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [csps_pkg::CFG_W-1:0]    cfg_data,
  output logic                          result_valid,
  output csps_pkg::result_t             result
);

`include "assert_macros.svh"

  localparam int PW = $clog2(MAX_PROCS);
  localparam int CW = PW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_CHK, S_FND_RD, S_FND_CK, S_LD_WR,
    S_ADM_RD, S_ADM_CK, S_SEL_Q, S_SEL_E, S_SEL_C1, S_SEL_C2, S_SEL_C3,
    S_DISP, S_CPT_RD, S_CPT_WR, S_RUN, S_WT_RD, S_WT_CK, S_FIN, S_OUT
  } state_t;

  state_t                          state;
  logic [csps_pkg::POL_W-1:0]      policy;
  logic [csps_pkg::SLICE_W-1:0]    time_slice;
  logic [MAX_PROCS-1:0]            valid;
  logic [CW-1:0]                   ready_count;
  logic [CW-1:0]                   live_count;
  logic [csps_pkg::TIME_W-1:0]     cur_time;
  logic                            running;
  logic [PW-1:0]                   run_pid;
  logic [csps_pkg::SLICE_W-1:0]    slice_used;
  csps_pkg::entry_t                run_e;
  csps_pkg::entry_t                best;
  csps_pkg::entry_t                cand;
  logic [PW-1:0]                   best_pid;
  logic [PW-1:0]                   cand_pid;
  logic [PW-1:0]                   best_pos;
  logic [CW-1:0]                   ptr;
  logic [CW-1:0]                   cptr;
  csps_pkg::cmd_t                  cmd_r;
  logic                            adm_second;
  logic                            cpt_load;
  logic                            lower;
  logic                            old_live;
  logic                            slot_idle;
  logic [PW-1:0]                   slot_pid;

  logic                            e_we;
  logic [PW-1:0]                   e_waddr;
  logic [PW-1:0]                   e_raddr;
  csps_pkg::entry_t                e_wdata;
  csps_pkg::entry_t                e_rdata;
  logic                            q_we;
  logic [PW-1:0]                   q_waddr;
  logic [PW-1:0]                   q_raddr;
  logic [PW-1:0]                   q_wdata;
  logic [PW-1:0]                   q_rdata;

  logic [PW-1:0]                   ldp;
  logic [PW-1:0]                   pidx;
  logic                            admit_hit;
  logic                            wait_hit;
  logic [csps_pkg::BURST_W-1:0]    burst_eff;
  logic [csps_pkg::SLICE_W-1:0]    ts_eff;
  logic                            pre;
  logic                            better;
  csps_pkg::cmp_ctl_t              cmp_ctl;
  logic [csps_pkg::TIME_W-1:0]     time_inc;

  csps_ram #(.WIDTH($bits(csps_pkg::entry_t)), .DEPTH(MAX_PROCS)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  csps_ram #(.WIDTH(PW), .DEPTH(MAX_PROCS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  assign cmp_ctl.capture = (state == S_SEL_C2);
  assign cmp_ctl.policy  = policy;

  csps_rank #(.PW(PW)) u_rank (
    .clk      (clk),
    .ctl      (cmp_ctl),
    .best     (best),
    .cand     (cand),
    .best_pid (best_pid),
    .cand_pid (cand_pid),
    .better   (better)
  );

  assign busy      = (state != S_IDLE);
  assign ldp       = PW'(cmd_r.pid);
  assign pidx      = ptr[PW-1:0];
  assign burst_eff = (cmd_r.burst == '0) ? csps_pkg::BURST_W'(1) : cmd_r.burst;
  assign ts_eff    = (time_slice == '0) ? csps_pkg::SLICE_W'(1) : time_slice;
  assign time_inc  = (cur_time != '1) ? cur_time + csps_pkg::TIME_W'(1) : cur_time;
  assign admit_hit = valid[pidx] && (e_rdata.phase == csps_pkg::PH_NEW) &&
                     (e_rdata.arrival <= cur_time);
  assign wait_hit  = valid[pidx] && (e_rdata.phase == csps_pkg::PH_READY);
  assign pre = (policy == csps_pkg::POL_SRTF) ||
               (((policy == csps_pkg::POL_RR) || (policy == csps_pkg::POL_PPRR)) &&
                (slice_used >= ts_eff)) ||
               ((policy == csps_pkg::POL_PPRR) && lower);

  always_comb begin
    e_we    = 1'b0;
    e_waddr = pidx;
    e_raddr = pidx;
    e_wdata = e_rdata;
    q_we    = 1'b0;
    q_waddr = ready_count[PW-1:0];
    q_wdata = pidx;
    q_raddr = pidx;
    unique case (state)
      S_LD_RD: e_raddr = ldp;
      S_LD_WR: begin
        e_we              = 1'b1;
        e_waddr           = ldp;
        e_wdata.phase     = csps_pkg::PH_NEW;
        e_wdata.arrival   = cmd_r.arrival;
        e_wdata.rank      = cmd_r.process_priority;
        e_wdata.burst     = burst_eff;
        e_wdata.remaining = burst_eff;
        e_wdata.waiting   = '0;
      end
      S_ADM_CK: begin
        if (admit_hit) begin
          e_we          = 1'b1;
          e_wdata.phase = csps_pkg::PH_READY;
          q_we          = 1'b1;
        end
      end
      S_SEL_E: e_raddr = q_rdata;
      S_DISP: begin
        e_we          = 1'b1;
        e_waddr       = best_pid;
        e_wdata       = best;
        e_wdata.phase = csps_pkg::PH_RUN;
      end
      S_CPT_RD: q_raddr = PW'(cptr + CW'(1));
      S_CPT_WR: begin
        q_we    = 1'b1;
        q_waddr = cptr[PW-1:0];
        q_wdata = q_rdata;
      end
      S_WT_CK: begin
        if (wait_hit && (e_rdata.waiting != '1)) begin
          e_we            = 1'b1;
          e_wdata.waiting = e_rdata.waiting + csps_pkg::TIME_W'(1);
        end
      end
      S_FIN: begin
        if (running) begin
          e_waddr = run_pid;
          e_wdata = run_e;
          if (run_e.remaining == '0) begin
            e_we          = 1'b1;
            e_wdata.phase = csps_pkg::PH_DONE;
          end else if (pre) begin
            e_we          = 1'b1;
            e_wdata.phase = csps_pkg::PH_READY;
            q_we          = 1'b1;
            q_wdata       = run_pid;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      policy       <= csps_pkg::POL_FCFS;
      time_slice   <= csps_pkg::SLICE_W'(1);
      valid        <= '0;
      ready_count  <= '0;
      live_count   <= '0;
      cur_time     <= '0;
      running      <= 1'b0;
      run_pid      <= '0;
      slice_used   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          csps_pkg::CFG_POLICY: policy <= cfg_data[csps_pkg::POL_W-1:0];
          csps_pkg::CFG_SLICE:  time_slice <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            if (cmd.op == csps_pkg::OP_TICK) begin
              ptr        <= '0;
              adm_second <= 1'b0;
              state      <= S_ADM_RD;
            end else if (9'(cmd.pid) < 9'(MAX_PROCS)) begin
              state <= S_LD_RD;
            end
          end
        end
        S_LD_RD: state <= S_LD_CHK;
        S_LD_CHK: begin
          old_live <= valid[ldp] && (e_rdata.phase != csps_pkg::PH_DONE);
          if (running && (run_pid == ldp)) running <= 1'b0;
          if (valid[ldp] && (e_rdata.phase == csps_pkg::PH_READY)) begin
            ptr   <= '0;
            state <= S_FND_RD;
          end else begin
            state <= S_LD_WR;
          end
        end
        S_FND_RD: state <= S_FND_CK;
        S_FND_CK: begin
          if (q_rdata == ldp) begin
            cptr     <= ptr;
            cpt_load <= 1'b1;
            state    <= S_CPT_RD;
          end else if ((ptr + CW'(1)) >= ready_count) begin
            state <= S_LD_WR;
          end else begin
            ptr   <= ptr + CW'(1);
            state <= S_FND_RD;
          end
        end
        S_LD_WR: begin
          valid[ldp] <= 1'b1;
          if (!old_live) live_count <= live_count + CW'(1);
          state <= S_IDLE;
        end
        S_ADM_RD: begin
          if (ptr == CW'(MAX_PROCS)) begin
            if (adm_second) begin
              state <= S_FIN;
            end else if (!running && (ready_count != '0)) begin
              ptr   <= '0;
              state <= S_SEL_Q;
            end else begin
              state <= S_RUN;
            end
          end else begin
            state <= S_ADM_CK;
          end
        end
        S_ADM_CK: begin
          if (admit_hit) begin
            ready_count <= ready_count + CW'(1);
            if (e_rdata.rank < run_e.rank) lower <= 1'b1;
          end
          ptr   <= ptr + CW'(1);
          state <= S_ADM_RD;
        end
        S_SEL_Q: state <= S_SEL_E;
        S_SEL_E: begin
          cand_pid <= q_rdata;
          state    <= S_SEL_C1;
        end
        S_SEL_C1: begin
          cand <= e_rdata;
          if (ptr == '0) begin
            best     <= e_rdata;
            best_pid <= cand_pid;
            best_pos <= '0;
            ptr      <= CW'(1);
            state    <= (ready_count <= CW'(1)) ? S_DISP : S_SEL_Q;
          end else begin
            state <= S_SEL_C2;
          end
        end
        S_SEL_C2: state <= S_SEL_C3;
        S_SEL_C3: begin
          if (better) begin
            best     <= cand;
            best_pid <= cand_pid;
            best_pos <= pidx;
          end
          ptr   <= ptr + CW'(1);
          state <= ((ptr + CW'(1)) >= ready_count) ? S_DISP : S_SEL_Q;
        end
        S_DISP: begin
          run_e      <= best;
          run_pid    <= best_pid;
          running    <= 1'b1;
          slice_used <= '0;
          cptr       <= CW'(best_pos);
          cpt_load   <= 1'b0;
          state      <= S_CPT_RD;
        end
        S_CPT_RD: begin
          if ((cptr + CW'(1)) >= ready_count) begin
            ready_count <= ready_count - CW'(1);
            state       <= cpt_load ? S_LD_WR : S_RUN;
          end else begin
            state <= S_CPT_WR;
          end
        end
        S_CPT_WR: begin
          cptr  <= cptr + CW'(1);
          state <= S_CPT_RD;
        end
        S_RUN: begin
          lower      <= 1'b0;
          ptr        <= '0;
          adm_second <= 1'b1;
          slot_idle  <= !running;
          slot_pid   <= running ? run_pid : '0;
          if (running) begin
            run_e.remaining <= run_e.remaining - csps_pkg::BURST_W'(1);
            if (slice_used != '1) slice_used <= slice_used + csps_pkg::SLICE_W'(1);
            state <= S_WT_RD;
          end else begin
            cur_time <= time_inc;
            state    <= S_ADM_RD;
          end
        end
        S_WT_RD: begin
          if (ptr == CW'(MAX_PROCS)) begin
            cur_time <= time_inc;
            ptr      <= '0;
            state    <= S_ADM_RD;
          end else begin
            state <= S_WT_CK;
          end
        end
        S_WT_CK: begin
          if (wait_hit && (e_rdata.rank < run_e.rank)) lower <= 1'b1;
          ptr   <= ptr + CW'(1);
          state <= S_WT_RD;
        end
        S_FIN: begin
          result.finished        <= 1'b0;
          result.finished_pid    <= '0;
          result.waiting_time    <= '0;
          result.turnaround_time <= '0;
          if (running) begin
            if (run_e.remaining == '0) begin
              running                <= 1'b0;
              live_count             <= live_count - CW'(1);
              result.finished        <= 1'b1;
              result.finished_pid    <= csps_pkg::PID_W'(run_pid);
              result.waiting_time    <= run_e.waiting;
              result.turnaround_time <= (cur_time >= run_e.arrival) ?
                                        cur_time - run_e.arrival : '0;
            end else if (pre) begin
              running     <= 1'b0;
              ready_count <= ready_count + CW'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          result_valid     <= 1'b1;
          result.slot_pid  <= csps_pkg::PID_W'(slot_pid);
          result.slot_idle <= slot_idle;
          result.all_done  <= (live_count == '0);
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSPS_ASSERT(a_strobe_single, clk, rst, result_valid |=> !result_valid)
  `CSPS_ASSERT(a_tick_busy, clk, rst, (start && !busy && (cmd.op == csps_pkg::OP_TICK)) |=> busy)
  `CSPS_ASSERT(a_finish_ran, clk, rst, (result_valid && result.finished) |-> !result.slot_idle)
  `CSPS_NEVER(a_queue_bound, clk, rst, ready_count > CW'(MAX_PROCS))
  `CSPS_NEVER(a_live_bound, clk, rst, live_count > CW'(MAX_PROCS))

endmodule

>>> tb/testbench.sv
// self-checking testbench of the tick driven cpu scheduler core
`timescale 1ns / 1ps

class sched_scoreboard;

  bit                           ent_valid [64];
  csps_pkg::phase_t             ent_phase [64];
  logic [csps_pkg::TIME_W-1:0]  ent_arrival [64];
  logic [csps_pkg::RANK_W-1:0]  ent_rank [64];
  logic [csps_pkg::BURST_W-1:0] ent_burst [64];
  logic [csps_pkg::BURST_W-1:0] ent_remaining [64];
  logic [csps_pkg::TIME_W-1:0]  ent_waiting [64];
  int                           ready_q[$];
  int                           now_ticks;
  int                           run_pid;
  bit                           run_valid;
  int                           slice_used;
  logic [csps_pkg::POL_W-1:0]   policy;
  logic [csps_pkg::SLICE_W-1:0] slice;
  csps_pkg::result_t            pending[$];
  int                           errors, n_ticks, n_loads, n_finished, n_idle;

  function new();
    foreach (ent_valid[i]) begin
      ent_valid[i] = 0;
      ent_phase[i] = csps_pkg::PH_NEW;
      ent_waiting[i] = '0;
      ent_remaining[i] = '0;
      ent_arrival[i] = '0;
    end
    now_ticks = 0;
    run_pid = 0;
    run_valid = 0;
    slice_used = 0;
    policy = csps_pkg::POL_FCFS;
    slice = 8'd1;
  endfunction

  function void push_ready(int p);
    ready_q.insert(ready_q.size(), p);
    ent_phase[p] = csps_pkg::PH_READY;
  endfunction

  function void admit_arrivals();
    for (int i = 0; i < 64; i++)
      if (ent_valid[i] && ent_phase[i] == csps_pkg::PH_NEW && ent_arrival[i] <= now_ticks)
        push_ready(i);
  endfunction

  function bit prefers(int cur, int cand);
    longint lhs, rhs;
    case (policy)
      csps_pkg::POL_SJF: begin
        if (ent_burst[cand] != ent_burst[cur]) return ent_burst[cand] < ent_burst[cur];
        return ent_arrival[cand] < ent_arrival[cur];
      end
      csps_pkg::POL_SRTF: begin
        if (ent_remaining[cand] != ent_remaining[cur])
          return ent_remaining[cand] < ent_remaining[cur];
        if (ent_arrival[cand] != ent_arrival[cur]) return ent_arrival[cand] < ent_arrival[cur];
        return cand < cur;
      end
      csps_pkg::POL_HRRN: begin
        lhs = (longint'(ent_waiting[cur]) + ent_burst[cur]) * ent_burst[cand];
        rhs = (longint'(ent_waiting[cand]) + ent_burst[cand]) * ent_burst[cur];
        if (lhs != rhs) return rhs > lhs;
        if (ent_arrival[cand] != ent_arrival[cur]) return ent_arrival[cand] < ent_arrival[cur];
        return cand < cur;
      end
      csps_pkg::POL_PPRR: return ent_rank[cand] < ent_rank[cur];
      default: return 0;
    endcase
  endfunction

  function void set_cfg(logic idx, logic [csps_pkg::CFG_W-1:0] data);
    if (idx == csps_pkg::CFG_POLICY) policy = data[csps_pkg::POL_W-1:0];
    else slice = data[csps_pkg::SLICE_W-1:0];
  endfunction

  function void note_cmd(csps_pkg::cmd_t c);
    int p, best, ts;
    bit pre, all;
    csps_pkg::result_t r;
    if (c.op == csps_pkg::OP_LOAD) begin
      p = c.pid;
      n_loads++;
      foreach (ready_q[k])
        if (ready_q[k] == p) begin
          ready_q.delete(k);
          break;
        end
      if (run_valid && run_pid == p) run_valid = 0;
      ent_valid[p] = 1;
      ent_phase[p] = csps_pkg::PH_NEW;
      ent_arrival[p] = c.arrival;
      ent_rank[p] = c.process_priority;
      ent_burst[p] = (c.burst == 0) ? 10'd1 : c.burst;
      ent_remaining[p] = ent_burst[p];
      ent_waiting[p] = '0;
      return;
    end
    n_ticks++;
    r = '0;
    admit_arrivals();
    if (!run_valid && ready_q.size() > 0) begin
      best = 0;
      for (int k = 1; k < ready_q.size(); k++)
        if (prefers(ready_q[best], ready_q[k])) best = k;
      run_pid = ready_q[best];
      ready_q.delete(best);
      ent_phase[run_pid] = csps_pkg::PH_RUN;
      run_valid = 1;
      slice_used = 0;
    end
    if (!run_valid) begin
      r.slot_idle = 1'b1;
      n_idle++;
      if (now_ticks < 65535) now_ticks++;
      admit_arrivals();
    end else begin
      p = run_pid;
      r.slot_pid = csps_pkg::PID_W'(p);
      if (ent_remaining[p] > 0) ent_remaining[p]--;
      foreach (ready_q[k])
        if (ent_waiting[ready_q[k]] != 16'hffff) ent_waiting[ready_q[k]]++;
      if (slice_used < 255) slice_used++;
      if (now_ticks < 65535) now_ticks++;
      admit_arrivals();
      if (ent_remaining[p] == 0) begin
        ent_phase[p] = csps_pkg::PH_DONE;
        run_valid = 0;
        n_finished++;
        r.finished = 1'b1;
        r.finished_pid = csps_pkg::PID_W'(p);
        r.waiting_time = ent_waiting[p];
        r.turnaround_time = (now_ticks >= ent_arrival[p]) ?
                            csps_pkg::TIME_W'(now_ticks - ent_arrival[p]) : '0;
      end else begin
        ts = (slice == 0) ? 1 : slice;
        if (policy == csps_pkg::POL_SRTF) begin
          run_valid = 0;
          push_ready(p);
        end else if (policy == csps_pkg::POL_RR || policy == csps_pkg::POL_PPRR) begin
          pre = slice_used >= ts;
          if (policy == csps_pkg::POL_PPRR)
            foreach (ready_q[k]) if (ent_rank[ready_q[k]] < ent_rank[p]) pre = 1;
          if (pre) begin
            run_valid = 0;
            push_ready(p);
          end
        end
      end
    end
    all = 1;
    for (int i = 0; i < 64; i++)
      if (ent_valid[i] && ent_phase[i] != csps_pkg::PH_DONE) all = 0;
    r.all_done = all;
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(csps_pkg::result_t got);
    csps_pkg::result_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %p", $realtime, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;

  logic                           clk = 0;
  logic                           rst = 1;
  logic                           start = 0;
  logic                           busy;
  csps_pkg::cmd_t                 cmd = '0;
  logic                           cfg_we = 0;
  logic                           cfg_index = 0;
  logic [csps_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           result_valid;
  csps_pkg::result_t              result;

  sched_scoreboard sb = new();
  int stall_cycles = 0;
  int sent = 0;

  cpu_scheduling_policy_simulator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (start && !busy) sb.note_cmd(cmd);
      if (result_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task send_beat(csps_pkg::cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task load(int pid, int burst, int arrival, int prio);
    csps_pkg::cmd_t c;
    c.op = csps_pkg::OP_LOAD;
    c.pid = csps_pkg::PID_W'(pid);
    c.burst = csps_pkg::BURST_W'(burst);
    c.arrival = csps_pkg::TIME_W'(arrival);
    c.process_priority = csps_pkg::RANK_W'(prio);
    send_beat(c);
  endtask

  task tick();
    csps_pkg::cmd_t c;
    c.op = csps_pkg::OP_TICK;
    c.pid = csps_pkg::PID_W'($urandom);
    c.burst = csps_pkg::BURST_W'($urandom);
    c.arrival = csps_pkg::TIME_W'($urandom);
    c.process_priority = csps_pkg::RANK_W'($urandom);
    send_beat(c);
  endtask

  // drain outstanding ticks, then let a trailing load settle
  task drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_cfg(logic idx, int data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= csps_pkg::CFG_W'(data);
    @(posedge clk);
    cfg_we <= 0;
    sb.set_cfg(idx, csps_pkg::CFG_W'(data));
    @(posedge clk);
  endtask

  function int near_arrival();
    int a;
    a = sb.now_ticks + $urandom_range(0, 8);
    return (a > 65535) ? 65535 : a;
  endfunction

  initial begin
    int pol, ts, n, ticks, pid, burst, arr;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed part
    write_cfg(csps_pkg::CFG_POLICY, csps_pkg::POL_FCFS);
    write_cfg(csps_pkg::CFG_SLICE, 1);
    tick();
    load(0, 0, 0, 0);
    load(63, 1023, 65535, 255);
    load(62, 1023, 0, 128);
    tick();
    tick();
    tick();
    load(62, 2, 0, 7);
    load(5, 3, 1, 1);
    load(9, 1, 0, 200);
    tick();
    load(5, 2, 0, 3);
    repeat (4) tick();
    load(63, 1, 0, 0);
    repeat (5) tick();
    drain();

    // random phases over all policy codes and a range of quantum settings
    pol = 0;
    while (sent < 1850) begin
      case ($urandom_range(0, 4))
        0: ts = 0;
        1: ts = 1;
        2: ts = 255;
        3: ts = 2;
        default: ts = $urandom_range(1, 4);
      endcase
      write_cfg(csps_pkg::CFG_POLICY, pol);
      write_cfg(csps_pkg::CFG_SLICE, ts);
      pol = (pol + 1) % 8;
      for (int i = 0; i < 64; i++)
        if (sb.ent_valid[i] && sb.ent_phase[i] != csps_pkg::PH_DONE &&
            (sb.ent_remaining[i] > 8 || sb.ent_arrival[i] > sb.now_ticks + 20))
          load(i, $urandom_range(1, 3), near_arrival(), $urandom);
      n = $urandom_range(2, 8);
      ticks = 4;
      for (int i = 0; i < n; i++) begin
        pid = $urandom_range(0, 63);
        burst = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6);
        arr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : near_arrival();
        load(pid, burst, arr, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
        ticks += (burst > 8) ? 8 : burst + 1;
      end
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 11) == 0)
          load($urandom_range(0, 63), $urandom_range(0, 6), near_arrival(), $urandom);
        tick();
      end
      drain();
    end

    $display("covered %0d loads and %0d ticks (%0d idle), %0d processes finished",
             sb.n_loads, sb.n_ticks, sb.n_idle, sb.n_finished);
    $display("policy codes cycled through all eight values with random quanta");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
